[hdl/pst_pkg.sv]
`default_nettype none
package pst_pkg;

	// particle kinds
	localparam logic [2:0] KIND_STATIC   = 3'd0;
	localparam logic [2:0] KIND_GRAV     = 3'd1;
	localparam logic [2:0] KIND_SLOWGRAV = 3'd2;
	localparam logic [2:0] KIND_FIRE     = 3'd3;
	localparam logic [2:0] KIND_EXPLODE  = 3'd4;
	localparam logic [2:0] KIND_EXPLODE2 = 3'd5;
	localparam logic [2:0] KIND_BLOB     = 3'd6;
	localparam logic [2:0] KIND_BLOB2    = 3'd7;

	// register indexes
	localparam logic [1:0] REG_CURRENT_TIME = 2'd0;
	localparam logic [1:0] REG_FRAME_TIME   = 2'd1;
	localparam logic [1:0] REG_GRAVITY      = 2'd2;

	localparam logic [11:0] GRAVITY_RESET = 12'd800;

	// velocity scale ops
	localparam logic [1:0] VOP_NONE   = 2'd0;
	localparam logic [1:0] VOP_GROW   = 2'd1; // v + v*ft*4
	localparam logic [1:0] VOP_DAMP16 = 2'd2; // v - v*ft
	localparam logic [1:0] VOP_DAMP14 = 2'd3; // v - v*ft*4

	// ramp steps per second, times 16
	localparam logic [3:0] RAMP_K_FIRE     = 4'd5;
	localparam logic [3:0] RAMP_K_EXPLODE  = 4'd10;
	localparam logic [3:0] RAMP_K_EXPLODE2 = 4'd15;
	localparam logic [3:0] RAMP_LIM_FIRE   = 4'd6;

	localparam logic [31:0] DEAD_MARK = 32'hFFFF0000;

	// x/320 = (x>>6)/5; x>>6 < 2^22, so ceil(2^25/5) is exact
	localparam logic [22:0] DIV5_RECIP = 23'd6710887;
	localparam int          DIV5_SHIFT = 25;

	typedef struct packed {
		logic       hold;
		logic [1:0] op;
	} axis_ctl_t;

	function automatic logic [31:0] sat_to32(input logic signed [34:0] v);
		logic [31:0] r;
		if (v > 35'sd2147483647)
			r = 32'h7FFFFFFF;
		else if (v < -35'sd2147483648)
			r = 32'h80000000;
		else
			r = v[31:0];
		return r;
	endfunction

	function automatic logic [7:0] ramp_color(input logic [2:0] kind, input logic [2:0] idx);
		logic [7:0] c;
		c = 8'h00;
		if (kind == KIND_FIRE) begin
			case (idx)
				3'd0: c = 8'h6d;
				3'd1: c = 8'h6b;
				3'd2: c = 8'h06;
				3'd3: c = 8'h05;
				3'd4: c = 8'h04;
				3'd5: c = 8'h03;
				default: c = 8'h00;
			endcase
		end else if (kind == KIND_EXPLODE) begin
			case (idx)
				3'd0: c = 8'h6f;
				3'd1: c = 8'h6d;
				3'd2: c = 8'h6b;
				3'd3: c = 8'h69;
				3'd4: c = 8'h67;
				3'd5: c = 8'h65;
				3'd6: c = 8'h63;
				default: c = 8'h61;
			endcase
		end else begin
			case (idx)
				3'd0: c = 8'h6f;
				3'd1: c = 8'h6e;
				3'd2: c = 8'h6d;
				3'd3: c = 8'h6c;
				3'd4: c = 8'h6b;
				3'd5: c = 8'h6a;
				3'd6: c = 8'h68;
				default: c = 8'h66;
			endcase
		end
		return c;
	endfunction

endpackage
`default_nettype wire

[hdl/pst_axis.sv]
`default_nettype none
// One axis: stage 1 registers vel*ft, stage 2 moves position and scales velocity.
module pst_axis (
	input  wire logic                 clk,
	input  wire logic signed [31:0]   pos,
	input  wire logic signed [31:0]   vel,
	input  wire logic        [15:0]   ft,
	input  wire pst_pkg::axis_ctl_t   ctl,
	output logic             [31:0]   new_pos_s2,
	output logic             [31:0]   new_vel_s2
);

	logic signed [47:0] prod_c;
	logic signed [47:0] prod_s1;
	logic signed [31:0] pos_s1;
	logic signed [31:0] vel_s1;
	pst_pkg::axis_ctl_t ctl_s1;
	logic signed [33:0] term14;
	logic signed [33:0] term16;
	logic signed [34:0] vel_ext;
	logic signed [34:0] sum_c;
	logic        [31:0] pos_c;
	logic        [31:0] vel_c;

	assign prod_c = vel * $signed({1'b0, ft});

	always_ff @(posedge clk) begin
		prod_s1 <= prod_c;
		pos_s1  <= pos;
		vel_s1  <= vel;
		ctl_s1  <= ctl;
	end

	// floor shifts of the product
	assign term14  = prod_s1[47:14];
	assign term16  = {{2{prod_s1[47]}}, prod_s1[47:16]};
	assign vel_ext = {{3{vel_s1[31]}}, vel_s1};

	always_comb begin
		case (ctl_s1.op)
			pst_pkg::VOP_GROW:   sum_c = vel_ext + {term14[33], term14};
			pst_pkg::VOP_DAMP16: sum_c = vel_ext - {term16[33], term16};
			pst_pkg::VOP_DAMP14: sum_c = vel_ext - {term14[33], term14};
			default:             sum_c = vel_ext;
		endcase
		if (ctl_s1.hold) begin
			pos_c = pos_s1;
			vel_c = vel_s1;
		end else begin
			pos_c = pos_s1 + prod_s1[47:16];
			vel_c = pst_pkg::sat_to32(sum_c);
		end
	end

	always_ff @(posedge clk) begin
		new_pos_s2 <= pos_c;
		new_vel_s2 <= vel_c;
	end

endmodule
`default_nettype wire

[hdl/particle_state_update.sv]
`default_nettype none
// Particle state update: advances one particle record by one frame.
//
// Input: drive the record on the field ports and pulse start; busy is
// always low, so an item is taken at every clock edge with start high.
// Items may follow each other in every cycle.
// Output: each item gives one result once it has passed stages 1 to 3,
// shown for one cycle with done high. The receiver cannot hold results
// off; results leave in input order.
// One item per cycle is sustained. The
// three stages are: multipliers (vel*ft per axis, ft*gravity, ramp
// step), position/velocity update plus the divide-by-5 reciprocal
// multiply, then gravity add and output registers.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 current_time, 1 frame_time, 2 gravity); write only while no item
// is in flight. Unused indexes are ignored.
// Reset (arst_n low): pipeline emptied, current_time 0, frame_time 0,
// gravity 800. No clearing pass.
module particle_state_update (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic        [1:0]  cfg_index,
	input  wire logic        [30:0] cfg_data,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [31:0] pos_x,
	input  wire logic signed [31:0] pos_y,
	input  wire logic signed [31:0] pos_z,
	input  wire logic signed [31:0] vel_x,
	input  wire logic signed [31:0] vel_y,
	input  wire logic signed [31:0] vel_z,
	input  wire logic        [15:0] ramp_in,
	input  wire logic        [2:0]  kind,
	input  wire logic        [7:0]  color_in,
	input  wire logic signed [31:0] death_time,
	output logic                    done,
	output logic                    alive,
	output logic signed [31:0]      new_pos_x,
	output logic signed [31:0]      new_pos_y,
	output logic signed [31:0]      new_pos_z,
	output logic signed [31:0]      new_vel_x,
	output logic signed [31:0]      new_vel_y,
	output logic signed [31:0]      new_vel_z,
	output logic        [15:0]      ramp_out,
	output logic        [7:0]       color_out,
	output logic signed [31:0]      new_death_time
);

	// configuration registers
	logic [30:0] current_time_q;
	logic [15:0] frame_time_q;
	logic [11:0] gravity_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_time_q <= '0;
			frame_time_q   <= '0;
			gravity_q      <= pst_pkg::GRAVITY_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				pst_pkg::REG_CURRENT_TIME: current_time_q <= cfg_data;
				pst_pkg::REG_FRAME_TIME:   frame_time_q   <= cfg_data[15:0];
				pst_pkg::REG_GRAVITY:      gravity_q      <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// valid bits
	logic v_s1, v_s2, v_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// ---------------- stage 1 ----------------
	logic               expired_c;
	pst_pkg::axis_ctl_t ctl_xy, ctl_z;
	logic [3:0]         ramp_k;
	logic [19:0]        ramp_prod;
	logic [16:0]        ramp_sum;

	// death earlier than now: particle is freed
	assign expired_c = death_time < $signed({1'b0, current_time_q});

	always_comb begin
		ctl_xy.hold = expired_c;
		ctl_z.hold  = expired_c;
		case (kind)
			pst_pkg::KIND_EXPLODE, pst_pkg::KIND_BLOB: begin
				ctl_xy.op = pst_pkg::VOP_GROW;
				ctl_z.op  = pst_pkg::VOP_GROW;
			end
			pst_pkg::KIND_EXPLODE2: begin
				ctl_xy.op = pst_pkg::VOP_DAMP16;
				ctl_z.op  = pst_pkg::VOP_DAMP16;
			end
			pst_pkg::KIND_BLOB2: begin
				// z is left to gravity alone
				ctl_xy.op = pst_pkg::VOP_DAMP14;
				ctl_z.op  = pst_pkg::VOP_NONE;
			end
			default: begin
				ctl_xy.op = pst_pkg::VOP_NONE;
				ctl_z.op  = pst_pkg::VOP_NONE;
			end
		endcase
	end

	always_comb begin
		case (kind)
			pst_pkg::KIND_FIRE:     ramp_k = pst_pkg::RAMP_K_FIRE;
			pst_pkg::KIND_EXPLODE:  ramp_k = pst_pkg::RAMP_K_EXPLODE;
			pst_pkg::KIND_EXPLODE2: ramp_k = pst_pkg::RAMP_K_EXPLODE2;
			default:                ramp_k = 4'd0;
		endcase
		if (expired_c)
			ramp_k = 4'd0;
	end

	assign ramp_prod = frame_time_q * ramp_k;
	assign ramp_sum  = {1'b0, ramp_in} + {1'b0, ramp_prod[19:4]};

	logic [2:0]  kind_s1;
	logic        expired_s1;
	logic        ramp_kind_s1;
	logic [15:0] ramp_s1;
	logic [7:0]  color_s1;
	logic [31:0] death_s1;
	logic [27:0] gprod_s1;

	always_ff @(posedge clk) begin
		kind_s1      <= kind;
		expired_s1   <= expired_c;
		ramp_kind_s1 <= (ramp_k != 4'd0);
		ramp_s1      <= ramp_sum[16] ? 16'hFFFF : ramp_sum[15:0];
		color_s1     <= color_in;
		death_s1     <= death_time;
		gprod_s1     <= frame_time_q * gravity_q;
	end

	// per-axis position and velocity (stages 1 and 2)
	logic [31:0] npos_x_s2, npos_y_s2, npos_z_s2;
	logic [31:0] nvel_x_s2, nvel_y_s2, nvel_z_s2;

	pst_axis u_axis_x (
		.clk        (clk),
		.pos        (pos_x),
		.vel        (vel_x),
		.ft         (frame_time_q),
		.ctl        (ctl_xy),
		.new_pos_s2 (npos_x_s2),
		.new_vel_s2 (nvel_x_s2)
	);

	pst_axis u_axis_y (
		.clk        (clk),
		.pos        (pos_y),
		.vel        (vel_y),
		.ft         (frame_time_q),
		.ctl        (ctl_xy),
		.new_pos_s2 (npos_y_s2),
		.new_vel_s2 (nvel_y_s2)
	);

	pst_axis u_axis_z (
		.clk        (clk),
		.pos        (pos_z),
		.vel        (vel_z),
		.ft         (frame_time_q),
		.ctl        (ctl_z),
		.new_pos_s2 (npos_z_s2),
		.new_vel_s2 (nvel_z_s2)
	);

	// ---------------- stage 2 ----------------
	logic       ramp_end_c;
	logic [7:0] color_c;
	logic [31:0] death_c;

	// ramp end: fire at 6.0, explode kinds at 8.0
	always_comb begin
		if (kind_s1 == pst_pkg::KIND_FIRE)
			ramp_end_c = (ramp_s1[15:12] >= pst_pkg::RAMP_LIM_FIRE);
		else
			ramp_end_c = ramp_s1[15];
		color_c = color_s1;
		death_c = death_s1;
		if (ramp_kind_s1) begin
			if (ramp_end_c)
				death_c = pst_pkg::DEAD_MARK;
			else
				color_c = pst_pkg::ramp_color(kind_s1, ramp_s1[14:12]);
		end
	end

	logic [2:0]  kind_s2;
	logic        expired_s2;
	logic [15:0] ramp_s2;
	logic [7:0]  color_s2;
	logic [31:0] death_s2;
	logic [44:0] gmul_s2;

	always_ff @(posedge clk) begin
		kind_s2    <= kind_s1;
		expired_s2 <= expired_s1;
		ramp_s2    <= ramp_s1;
		color_s2   <= color_c;
		death_s2   <= death_c;
		gmul_s2    <= gprod_s1[27:6] * pst_pkg::DIV5_RECIP;
	end

	// ---------------- stage 3 ----------------
	logic [19:0]        grav_q;
	logic signed [34:0] vz_ext;
	logic signed [34:0] vz_sum;
	logic [31:0]        vz_c;

	// floor(ft * gravity / 320)
	assign grav_q = gmul_s2[pst_pkg::DIV5_SHIFT +: 20];
	assign vz_ext = {{3{nvel_z_s2[31]}}, nvel_z_s2};

	always_comb begin
		vz_sum = vz_ext;
		if (kind_s2 == pst_pkg::KIND_FIRE)
			vz_sum = vz_ext + {15'd0, grav_q};
		else if (kind_s2 != pst_pkg::KIND_STATIC)
			vz_sum = vz_ext - {15'd0, grav_q};
		if (expired_s2)
			vz_c = nvel_z_s2;
		else
			vz_c = pst_pkg::sat_to32(vz_sum);
	end

	logic        alive_s3;
	logic [31:0] pos_x_s3, pos_y_s3, pos_z_s3;
	logic [31:0] vel_x_s3, vel_y_s3, vel_z_s3;
	logic [15:0] ramp_s3;
	logic [7:0]  color_s3;
	logic [31:0] death_s3;

	always_ff @(posedge clk) begin
		alive_s3 <= !expired_s2;
		pos_x_s3 <= npos_x_s2;
		pos_y_s3 <= npos_y_s2;
		pos_z_s3 <= npos_z_s2;
		vel_x_s3 <= nvel_x_s2;
		vel_y_s3 <= nvel_y_s2;
		vel_z_s3 <= vz_c;
		ramp_s3  <= ramp_s2;
		color_s3 <= color_s2;
		death_s3 <= death_s2;
	end

	assign done           = v_s3;
	assign alive          = alive_s3;
	assign new_pos_x      = pos_x_s3;
	assign new_pos_y      = pos_y_s3;
	assign new_pos_z      = pos_z_s3;
	assign new_vel_x      = vel_x_s3;
	assign new_vel_y      = vel_y_s3;
	assign new_vel_z      = vel_z_s3;
	assign ramp_out       = ramp_s3;
	assign color_out      = color_s3;
	assign new_death_time = death_s3;

endmodule
`default_nettype wire
